>>> design/napt_pkg.sv
// ----------------------------------------------------------------------------
// napt_pkg
// shared types and constants of the port translation table
// ----------------------------------------------------------------------------
`default_nettype none

package napt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [15:0] PORT_START           = 16'd49000;
    localparam logic [31:0] SUBNET_RESET         = 32'h0000_0000;
    localparam logic [1:0]  SUBNET_BYTES_RESET   = 2'd3;
    localparam logic [31:0] PUBLIC_RESET         = 32'h0000_0000;
    localparam logic [31:0] DEFAULT_INSIDE_RESET = 32'hC0A8_0164;

    typedef enum logic [2:0] {
        ST_UNTOUCHED = 3'd0,
        ST_MAPPED    = 3'd1,
        ST_NEW       = 3'd2,
        ST_DEFAULT   = 3'd3,
        ST_FULL      = 3'd4,
        ST_NOPORTS   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CFG_PRIVATE_SUBNET = 2'd0,
        CFG_SUBNET_BYTES   = 2'd1,
        CFG_PUBLIC_ADDRESS = 2'd2,
        CFG_DEFAULT_INSIDE = 2'd3
    } cfg_reg_t;

    // search key broadcast to every cell
    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] sport;
        logic [7:0]  proto;
        logic [15:0] kport;
    } query_t;

    // entry write broadcast to every cell
    typedef struct packed {
        logic        en;
        logic [7:0]  proto;
        logic [15:0] kport;
        logic [31:0] addr;
        logic [15:0] iport;
    } entry_wr_t;

    // partial search result handed from cell to cell
    typedef struct packed {
        logic        tok;
        logic        in_hit;
        logic [15:0] in_port;
        logic        key_hit;
        logic [31:0] key_addr;
        logic [15:0] key_port;
    } link_t;

endpackage

`default_nettype wire

>>> design/napt_cell.sv
// ----------------------------------------------------------------------------
// napt_cell
// one table entry with its compare logic and a registered link to the next
// ----------------------------------------------------------------------------
`default_nettype none

module napt_cell import napt_pkg::*; #(
    parameter int IDX_W      = 6,
    parameter int CELL_INDEX = 0
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire query_t           query,
    input  wire entry_wr_t        wr,
    input  wire logic [IDX_W-1:0] wr_idx,
    input  wire link_t            link_in,
    input  wire logic [IDX_W-1:0] idx_in,
    output link_t                 link_out,
    output logic [IDX_W-1:0]      idx_out
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

    logic             valid_reg;
    logic [7:0]       key_proto_reg;
    logic [15:0]      key_port_reg;
    logic [31:0]      ins_addr_reg;
    logic [15:0]      ins_port_reg;
    link_t            link_reg;
    link_t            link_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             wr_hit;
    logic             in_match;
    logic             key_match;

    assign wr_hit    = wr.en && (wr_idx == MY_IDX);
    assign in_match  = valid_reg && (ins_addr_reg == query.addr)
                       && (ins_port_reg == query.sport);
    assign key_match = valid_reg && (key_proto_reg == query.proto)
                       && (key_port_reg == query.kport);

    always_comb
    begin
        link_next = link_in;
        idx_next  = idx_in;
        if (!link_in.in_hit && in_match)
        begin
            link_next.in_hit  = 1'b1;
            link_next.in_port = key_port_reg;
        end
        if (!link_in.key_hit && key_match)
        begin
            link_next.key_hit  = 1'b1;
            link_next.key_addr = ins_addr_reg;
            link_next.key_port = ins_port_reg;
            idx_next           = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            link_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (wr_hit)
            begin
                valid_reg <= 1'b1;
            end
            link_reg <= link_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_hit)
        begin
            key_proto_reg <= wr.proto;
            key_port_reg  <= wr.kport;
            ins_addr_reg  <= wr.addr;
            ins_port_reg  <= wr.iport;
        end
    end

    assign link_out = link_reg;
    assign idx_out  = idx_reg;

endmodule

`default_nettype wire

>>> design/napt_port_translation_table.sv
// ----------------------------------------------------------------------------
// napt_port_translation_table
// address and port translation of ipv4 headers against a mapping table
// ----------------------------------------------------------------------------
// Each header word is classified against the private subnet and then searched
// through a row of TABLE_ENTRIES cells, one cell per clock; a new word is
// accepted once the previous search has handed its result to the output
// register. Outgoing words with ports from inside the subnet get the public
// address and an existing or newly allocated external port, those without
// ports get only the public address; incoming words from outside are mapped
// back by protocol and port, or sent to the default inside address. Status 4
// flags a full table.
// ----------------------------------------------------------------------------
`default_nettype none

module napt_port_translation_table import napt_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // src_addr, dst_addr, proto_num, src_port, dst_port
    input  wire logic [103:0] s_axis_tdata,
    // req_type, has_ports
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_src_addr, out_src_port, out_dst_addr, out_dst_port
    output logic [95:0]       m_axis_tdata,
    // status
    output logic [2:0]        m_axis_tuser,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FINISH
    } state_t;

    state_t      state_reg;
    logic        start_reg;
    logic        m_tvalid_reg;
    status_t     status_reg;
    logic [31:0] osrc_reg;
    logic [15:0] osport_reg;
    logic [31:0] odst_reg;
    logic [15:0] odport_reg;
    logic [15:0] next_port_reg;
    logic [CNT_W-1:0] entries_used_reg;

    logic [31:0] private_subnet_reg;
    logic [1:0]  subnet_bytes_reg;
    logic [31:0] public_address_reg;
    logic [31:0] default_inside_reg;

    query_t      query_reg;
    logic        req_reg;
    logic        ports_reg;
    logic [31:0] dst_reg;
    logic [15:0] dport_reg;
    logic        cls_out_reg;
    logic        cls_in_reg;

    logic             res_in_hit_reg;
    logic [15:0]      res_in_port_reg;
    logic             res_key_hit_reg;
    logic [31:0]      res_key_addr_reg;
    logic [15:0]      res_key_port_reg;
    logic [IDX_W-1:0] res_idx_reg;

    logic [31:0] in_src_addr;
    logic [31:0] in_dst_addr;
    logic [7:0]  in_proto;
    logic [15:0] in_sport;
    logic [15:0] in_dport;
    logic [31:0] mask;
    logic        src_in;
    logic        dst_in;
    logic        in_fire;
    logic        out_free;
    logic        fire;

    status_t     status_next;
    logic [31:0] osrc_next;
    logic [15:0] osport_next;
    logic [31:0] odst_next;
    logic [15:0] odport_next;
    logic        alloc;
    logic        fresh;
    logic        full;

    entry_wr_t        wr;
    logic [IDX_W-1:0] wr_idx;

    link_t            links [TABLE_ENTRIES+1];
    logic [IDX_W-1:0] idxs  [TABLE_ENTRIES+1];

    assign in_src_addr = s_axis_tdata[31:0];
    assign in_dst_addr = s_axis_tdata[63:32];
    assign in_proto    = s_axis_tdata[71:64];
    assign in_sport    = s_axis_tdata[87:72];
    assign in_dport    = s_axis_tdata[103:88];

    always_comb
    begin
        case (subnet_bytes_reg)
            2'd3:    mask = 32'hFFFF_FF00;
            2'd2:    mask = 32'hFFFF_0000;
            default: mask = 32'hFF00_0000;
        endcase
    end

    assign src_in = (in_src_addr & mask) == (private_subnet_reg & mask);
    assign dst_in = (in_dst_addr & mask) == (private_subnet_reg & mask);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_tvalid_reg || m_axis_tready;
    assign fire          = (state_reg == S_FINISH) && out_free;
    assign cfg_ready     = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            private_subnet_reg <= SUBNET_RESET;
            subnet_bytes_reg   <= SUBNET_BYTES_RESET;
            public_address_reg <= PUBLIC_RESET;
            default_inside_reg <= DEFAULT_INSIDE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_PRIVATE_SUBNET: private_subnet_reg <= cfg_data;
                CFG_SUBNET_BYTES:   subnet_bytes_reg   <= cfg_data[1:0];
                CFG_PUBLIC_ADDRESS: public_address_reg <= cfg_data;
                CFG_DEFAULT_INSIDE: default_inside_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // query and search result capture
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            query_reg.addr  <= in_src_addr;
            query_reg.sport <= in_sport;
            query_reg.proto <= in_proto;
            query_reg.kport <= s_axis_tuser[0] ? in_dport : (next_port_reg + 16'd1);
            req_reg         <= s_axis_tuser[0];
            ports_reg       <= s_axis_tuser[1];
            dst_reg         <= in_dst_addr;
            dport_reg       <= in_dport;
            cls_out_reg     <= src_in && !dst_in;
            cls_in_reg      <= !src_in && !dst_in;
        end
        if (state_reg == S_SEARCH && links[TABLE_ENTRIES].tok)
        begin
            res_in_hit_reg   <= links[TABLE_ENTRIES].in_hit;
            res_in_port_reg  <= links[TABLE_ENTRIES].in_port;
            res_key_hit_reg  <= links[TABLE_ENTRIES].key_hit;
            res_key_addr_reg <= links[TABLE_ENTRIES].key_addr;
            res_key_port_reg <= links[TABLE_ENTRIES].key_port;
            res_idx_reg      <= idxs[TABLE_ENTRIES];
        end
    end

    // translation decision
    assign full = (entries_used_reg == CNT_W'(TABLE_ENTRIES));

    always_comb
    begin
        status_next = ST_UNTOUCHED;
        osrc_next   = query_reg.addr;
        osport_next = query_reg.sport;
        odst_next   = dst_reg;
        odport_next = dport_reg;
        alloc       = 1'b0;
        fresh       = 1'b0;
        if (!req_reg)
        begin
            if (cls_out_reg)
            begin
                if (!ports_reg)
                begin
                    status_next = ST_NOPORTS;
                    osrc_next   = public_address_reg;
                end
                else if (res_in_hit_reg)
                begin
                    status_next = ST_MAPPED;
                    osrc_next   = public_address_reg;
                    osport_next = res_in_port_reg;
                end
                else if (res_key_hit_reg || !full)
                begin
                    alloc       = 1'b1;
                    fresh       = !res_key_hit_reg;
                    status_next = ST_NEW;
                    osrc_next   = public_address_reg;
                    osport_next = query_reg.kport;
                end
                else
                begin
                    status_next = ST_FULL;
                end
            end
        end
        else if (cls_in_reg)
        begin
            if (ports_reg && res_key_hit_reg)
            begin
                status_next = ST_MAPPED;
                odst_next   = res_key_addr_reg;
                odport_next = res_key_port_reg;
            end
            else
            begin
                status_next = ST_DEFAULT;
                odst_next   = default_inside_reg;
            end
        end
    end

    assign wr_idx   = res_key_hit_reg ? res_idx_reg : entries_used_reg[IDX_W-1:0];
    assign wr.en    = fire && alloc;
    assign wr.proto = query_reg.proto;
    assign wr.kport = query_reg.kport;
    assign wr.addr  = query_reg.addr;
    assign wr.iport = query_reg.sport;

    // control state and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            start_reg        <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            status_reg       <= ST_UNTOUCHED;
            osrc_reg         <= '0;
            osport_reg       <= '0;
            odst_reg         <= '0;
            odport_reg       <= '0;
            next_port_reg    <= PORT_START;
            entries_used_reg <= '0;
        end
        else
        begin
            start_reg <= in_fire;
            if (fire)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    if (links[TABLE_ENTRIES].tok)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        status_reg   <= status_next;
                        osrc_reg     <= osrc_next;
                        osport_reg   <= osport_next;
                        odst_reg     <= odst_next;
                        odport_reg   <= odport_next;
                        if (alloc)
                        begin
                            next_port_reg <= query_reg.kport;
                        end
                        if (fresh)
                        begin
                            entries_used_reg <= entries_used_reg + CNT_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {odport_reg, odst_reg, osport_reg, osrc_reg};

    // row of table cells
    assign links[0] = link_t'{tok: start_reg, default: '0};
    assign idxs[0]  = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        napt_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .query    (query_reg),
            .wr       (wr),
            .wr_idx   (wr_idx),
            .link_in  (links[g]),
            .idx_in   (idxs[g]),
            .link_out (links[g+1]),
            .idx_out  (idxs[g+1])
        );
    end

endmodule

`default_nettype wire

>>> bench/napt_port_translation_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// napt_port_translation_table_test
// self-checking bench for the address and port translation table
// ----------------------------------------------------------------------------
// Header words go in on the slave stream and translated words come out on the
// master stream. A mirror of the mapping table predicts every translated word
// from the accepted header words and the register writes seen on the config
// channel. The run steps through six register settings, with a directed set
// of headers first and then random traffic that reuses live mappings, asks
// for new ones until the table is full, and looks mappings up from outside.
// Both streams idle and stall at random, and the receiver holds off once for
// a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------

module napt_port_translation_table_test;
    import napt_pkg::*;

    localparam int TABLE_ENTRIES    = TABLE_ENTRIES_DEF;
    localparam int PHASES           = 6;
    localparam int RANDOM_PER_PHASE = 92;
    localparam int LIMIT_CYCLES     = 1000000;
    localparam int DRAIN_CYCLES     = TABLE_ENTRIES + 16;

    typedef enum logic {
        HOOK_POSTROUTING = 1'b0,
        HOOK_PREROUTING  = 1'b1
    } hook_t;

    // laid out as {tuser, tdata} of the slave stream
    typedef struct packed {
        logic        has_ports;
        hook_t       req_type;
        logic [15:0] dst_port;
        logic [15:0] src_port;
        logic [7:0]  proto;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
    } header_t;

    // laid out as {tuser, tdata} of the master stream
    typedef struct packed {
        status_t     status;
        logic [15:0] dst_port;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [31:0] src_addr;
    } xlate_t;

    class translation_checker;
        logic [31:0] subnet;
        logic [1:0]  prefix_bytes;
        logic [31:0] public_addr;
        logic [31:0] default_inside;
        bit          key_valid [TABLE_ENTRIES];
        logic [7:0]  key_proto [TABLE_ENTRIES];
        logic [15:0] key_port [TABLE_ENTRIES];
        logic [31:0] inside_addr [TABLE_ENTRIES];
        logic [15:0] inside_port [TABLE_ENTRIES];
        logic [15:0] next_port;
        xlate_t      pending_translations [$];
        int          mismatches;

        function new();
            subnet         = SUBNET_RESET;
            prefix_bytes   = SUBNET_BYTES_RESET;
            public_addr    = PUBLIC_RESET;
            default_inside = DEFAULT_INSIDE_RESET;
            next_port      = PORT_START;
            mismatches     = 0;
            foreach (key_valid[i])
                key_valid[i] = 1'b0;
        endfunction

        function void apply_register(cfg_reg_t idx, logic [31:0] value);
            case (idx)
                CFG_PRIVATE_SUBNET: subnet = value;
                CFG_SUBNET_BYTES:   prefix_bytes = value[1:0];
                CFG_PUBLIC_ADDRESS: public_addr = value;
                CFG_DEFAULT_INSIDE: default_inside = value;
                default:            ;
            endcase
        endfunction

        function logic [31:0] subnet_mask();
            case (prefix_bytes)
                2'd3:    return 32'hFFFF_FF00;
                2'd2:    return 32'hFFFF_0000;
                default: return 32'hFF00_0000;
            endcase
        endfunction

        function bit in_private(logic [31:0] addr);
            return (addr & subnet_mask()) == (subnet & subnet_mask());
        endfunction

        function logic [31:0] inside_address();
            return (subnet & subnet_mask()) | ($urandom() & ~subnet_mask());
        endfunction

        function logic [31:0] outside_address();
            logic [31:0] addr;
            addr = $urandom();
            if (in_private(addr))
                addr[31] = ~addr[31];
            return addr;
        endfunction

        // random live entry, or -1 while the table is empty
        function int pick_entry();
            int live [$];
            foreach (key_valid[i])
                if (key_valid[i])
                    live.push_back(i);
            if (live.size() == 0)
                return -1;
            return live[$urandom_range(live.size() - 1)];
        endfunction

        function int find_key(logic [7:0] proto, logic [15:0] port);
            int slot;
            slot = -1;
            foreach (key_valid[i])
                if (slot < 0 && key_valid[i] && key_proto[i] == proto && key_port[i] == port)
                    slot = i;
            return slot;
        endfunction

        function xlate_t translate_header(header_t h);
            xlate_t      r;
            int          slot;
            logic [15:0] cand;
            r.status   = ST_UNTOUCHED;
            r.src_addr = h.src_addr;
            r.src_port = h.src_port;
            r.dst_addr = h.dst_addr;
            r.dst_port = h.dst_port;
            slot = -1;
            if (h.req_type == HOOK_POSTROUTING)
            begin
                if (in_private(h.src_addr) && !in_private(h.dst_addr))
                begin
                    if (!h.has_ports)
                    begin
                        r.status   = ST_NOPORTS;
                        r.src_addr = public_addr;
                    end
                    else
                    begin
                        // outgoing lookup ignores the protocol, lowest index wins
                        foreach (key_valid[i])
                            if (slot < 0 && key_valid[i] && inside_addr[i] == h.src_addr
                                && inside_port[i] == h.src_port)
                                slot = i;
                        if (slot >= 0)
                        begin
                            r.status   = ST_MAPPED;
                            r.src_addr = public_addr;
                            r.src_port = key_port[slot];
                        end
                        else
                        begin
                            cand = next_port + 16'd1;
                            slot = find_key(h.proto, cand);
                            if (slot < 0)
                                foreach (key_valid[i])
                                    if (slot < 0 && !key_valid[i])
                                        slot = i;
                            if (slot < 0)
                                r.status = ST_FULL;
                            else
                            begin
                                next_port         = cand;
                                key_valid[slot]   = 1'b1;
                                key_proto[slot]   = h.proto;
                                key_port[slot]    = cand;
                                inside_addr[slot] = h.src_addr;
                                inside_port[slot] = h.src_port;
                                r.status          = ST_NEW;
                                r.src_addr        = public_addr;
                                r.src_port        = cand;
                            end
                        end
                    end
                end
            end
            else if (!in_private(h.src_addr) && !in_private(h.dst_addr))
            begin
                if (h.has_ports)
                    slot = find_key(h.proto, h.dst_port);
                if (slot >= 0)
                begin
                    r.status   = ST_MAPPED;
                    r.dst_addr = inside_addr[slot];
                    r.dst_port = inside_port[slot];
                end
                else
                begin
                    r.status   = ST_DEFAULT;
                    r.dst_addr = default_inside;
                end
            end
            return r;
        endfunction

        function void take_header(header_t h);
            pending_translations.push_back(translate_header(h));
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        endfunction

        function void check_translation(xlate_t got);
            xlate_t want;
            if (pending_translations.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                return;
            end
            want = pending_translations.pop_front();
            if (got.status !== want.status)
                report("status", 32'(want.status), 32'(got.status));
            if (got.src_addr !== want.src_addr)
                report("out_src_addr", want.src_addr, got.src_addr);
            if (got.src_port !== want.src_port)
                report("out_src_port", 32'(want.src_port), 32'(got.src_port));
            if (got.dst_addr !== want.dst_addr)
                report("out_dst_addr", want.dst_addr, got.dst_addr);
            if (got.dst_port !== want.dst_port)
                report("out_dst_port", 32'(want.dst_port), 32'(got.dst_port));
        endfunction
    endclass

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [103:0]  s_axis_tdata = '0;
    logic [1:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [95:0]   m_axis_tdata;
    logic [2:0]    m_axis_tuser;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [1:0]    cfg_index = '0;
    logic [31:0]   cfg_data = '0;

    translation_checker mirror;
    int feed_idle_pct = 0;
    int drain_idle_pct = 0;
    int hold_cycles = 0;
    int cycle_count = 0;

    napt_port_translation_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),    // src_addr, dst_addr, proto_num, src_port, dst_port
        .s_axis_tuser(s_axis_tuser),    // req_type, has_ports
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),    // out_src_addr, out_src_port, out_dst_addr, out_dst_port
        .m_axis_tuser(m_axis_tuser),    // status
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stalls, with a counted hold-off on request
    always @(posedge clk)
    begin
        if (hold_cycles != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= drain_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                mirror.apply_register(cfg_reg_t'(cfg_index), cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                mirror.take_header({s_axis_tuser, s_axis_tdata});
            if (m_axis_tvalid && m_axis_tready)
                mirror.check_translation({m_axis_tuser, m_axis_tdata});
        end
    end

    task automatic set_register(input cfg_reg_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure_phase(input int phase);
        logic [31:0] subnet;
        logic [1:0]  prefix_bytes;
        logic [31:0] public_addr;
        logic [31:0] default_inside;
        case (phase)
            0:
            begin
                subnet = 32'hC0A8_0100; prefix_bytes = 2'd3;
                public_addr = 32'hFFFF_FFFF; default_inside = DEFAULT_INSIDE_RESET;
            end
            1:
            begin
                subnet = 32'h0A00_0000; prefix_bytes = 2'd1;
                public_addr = 32'h0102_0304; default_inside = 32'h0000_0000;
            end
            2:
            begin
                subnet = 32'hAC10_0000; prefix_bytes = 2'd2;
                public_addr = 32'h0000_0000; default_inside = 32'hFFFF_FFFF;
            end
            3:
            begin
                // prefix code zero falls back to /8
                subnet = 32'hFFFF_FFFF; prefix_bytes = 2'd0;
                public_addr = 32'h8C52_1E05; default_inside = 32'h0A0A_0A0A;
            end
            4:
            begin
                subnet = 32'h0000_0000; prefix_bytes = 2'd3;
                public_addr = 32'h7F00_0001; default_inside = 32'hC0A8_0101;
            end
            default:
            begin
                subnet = $urandom(); prefix_bytes = 2'($urandom_range(3, 1));
                public_addr = $urandom(); default_inside = $urandom();
            end
        endcase
        set_register(CFG_PRIVATE_SUBNET, subnet);
        set_register(CFG_SUBNET_BYTES, {30'd0, prefix_bytes});
        set_register(CFG_PUBLIC_ADDRESS, public_addr);
        set_register(CFG_DEFAULT_INSIDE, default_inside);
    endtask

    task automatic offer_header(input header_t h);
        if (feed_idle_pct != 0 && $urandom_range(99) < feed_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < feed_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        {s_axis_tuser, s_axis_tdata} <= h;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        @(posedge clk);
        while (mirror.pending_translations.size() != 0)
            @(posedge clk);
    endtask

    function automatic header_t make_header(hook_t req, logic [31:0] src, logic [31:0] dst,
                                            logic [7:0] proto, logic ports,
                                            logic [15:0] sport, logic [15:0] dport);
        header_t h;
        h.req_type  = req;
        h.src_addr  = src;
        h.dst_addr  = dst;
        h.proto     = proto;
        h.has_ports = ports;
        h.src_port  = sport;
        h.dst_port  = dport;
        return h;
    endfunction

    // mostly well-formed traffic aimed at live mappings, the rest noise
    function automatic header_t random_header();
        header_t h;
        int      pick;
        int      slot;
        h = make_header(hook_t'($urandom_range(1)), $urandom(), $urandom(),
                        8'($urandom_range(255)), ($urandom_range(9) != 0),
                        16'($urandom_range(65535)), 16'($urandom_range(65535)));
        pick = $urandom_range(99);
        slot = mirror.pick_entry();
        if (pick < 45)
        begin
            h.req_type = HOOK_POSTROUTING;
            h.src_addr = mirror.inside_address();
            h.dst_addr = mirror.outside_address();
            if (slot >= 0 && $urandom_range(99) < 60)
            begin
                h.src_addr = mirror.inside_addr[slot];
                h.src_port = mirror.inside_port[slot];
            end
        end
        else if (pick < 80)
        begin
            h.req_type = HOOK_PREROUTING;
            h.src_addr = mirror.outside_address();
            h.dst_addr = mirror.outside_address();
            if (slot >= 0 && $urandom_range(99) < 70)
            begin
                h.proto    = mirror.key_proto[slot];
                h.dst_port = mirror.key_port[slot];
            end
        end
        return h;
    endfunction

    initial
    begin
        mirror = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < PHASES; phase++)
        begin
            feed_idle_pct  = (phase < 2) ? 22 : (phase < 4) ? 86 : 0;
            drain_idle_pct = (phase < 2) ? 86 : (phase < 4) ? 22 : 0;
            configure_phase(phase);
            if (phase == 0)
            begin
                offer_header(make_header(HOOK_POSTROUTING, 32'hC0A8_0105, 32'h0808_0808,
                                         8'd6, 1'b1, 16'd0, 16'd65535));
                offer_header(make_header(HOOK_POSTROUTING, 32'hC0A8_0105, 32'h0808_0808,
                                         8'd17, 1'b1, 16'd0, 16'd80));
                offer_header(make_header(HOOK_POSTROUTING, 32'hC0A8_0106, 32'h0101_0101,
                                         8'd1, 1'b0, 16'd0, 16'd0));
                offer_header(make_header(HOOK_POSTROUTING, 32'hC0A8_01FF, 32'hFFFF_FFFF,
                                         8'd255, 1'b1, 16'd65535, 16'd0));
                offer_header(make_header(HOOK_POSTROUTING, 32'hC0A8_0100, 32'h0000_0000,
                                         8'd0, 1'b1, 16'd1234, 16'd443));
                offer_header(make_header(HOOK_POSTROUTING, 32'h0A00_0001, 32'h0808_0808,
                                         8'd6, 1'b1, 16'd5, 16'd5));
                offer_header(make_header(HOOK_POSTROUTING, 32'hC0A8_0105, 32'hC0A8_0107,
                                         8'd6, 1'b1, 16'd0, 16'd80));
                offer_header(make_header(HOOK_PREROUTING, 32'h0808_0808, 32'h0D0D_0D0D,
                                         8'd6, 1'b1, 16'd80, 16'd49001));
                offer_header(make_header(HOOK_PREROUTING, 32'h0808_0808, 32'h0D0D_0D0D,
                                         8'd17, 1'b1, 16'd80, 16'd49001));
                offer_header(make_header(HOOK_PREROUTING, 32'h0808_0808, 32'h0D0D_0D0D,
                                         8'd6, 1'b0, 16'd80, 16'd49001));
                offer_header(make_header(HOOK_PREROUTING, 32'hC0A8_0109, 32'h0D0D_0D0D,
                                         8'd6, 1'b1, 16'd80, 16'd49001));
                offer_header(make_header(HOOK_PREROUTING, 32'h0808_0808, 32'hC0A8_0109,
                                         8'd6, 1'b1, 16'd80, 16'd49001));
                offer_header(make_header(HOOK_PREROUTING, 32'h0000_0000, 32'hFFFF_FFFF,
                                         8'd255, 1'b1, 16'd65535, 16'd49002));
                offer_header(make_header(HOOK_PREROUTING, 32'hFFFF_FFFF, 32'h0000_0000,
                                         8'd0, 1'b1, 16'd0, 16'd0));
                offer_header(make_header(HOOK_PREROUTING, 32'h0102_0304, 32'h0506_0708,
                                         8'd0, 1'b1, 16'd0, 16'd49003));
                offer_header(make_header(HOOK_POSTROUTING, 32'hC0A8_01FF, 32'hFFFF_FFFF,
                                         8'd6, 1'b1, 16'd65535, 16'd65535));
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                if (phase == 1 && n == 40)
                    hold_cycles <= 400;
                if (phase == 4 && n == 46)
                begin
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                end
                offer_header(random_header());
            end
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
